>>> hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Constants, codes and types shared by the circular deque modules.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 16;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int ACT_W      = 3;
	localparam int DIN_W      = 16;
	localparam int STAT_W     = 2;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 24;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              is_empty;
		logic              is_full;
		logic              use_rd;
	} res_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} ram_req_t;

endpackage

>>> hdl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a circular RAM with wrapping front and rear indices.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled by a low m_tready.
//   The RAM read and the index update happen at accept; the read data and
//   res_s1 are registered, then placed in the output word m_tdata.
// Reset: asynchronous, leaves the deque empty; the RAM contents are not
//   cleared and no clearing pass is needed.
module circular_deque (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [2:0] action, [18:3] data_in, [23:19] zero
	input  logic [cdq_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] data_out, [17:16] status, [18] is_empty, [19] is_full, [23:20] zero
	output logic [cdq_pkg::M_TDATA_W-1:0]   m_tdata
);
	import cdq_pkg::*;

	logic                  accept, advance;
	logic                  valid_s1;
	res_t                  res, res_s1;
	ram_req_t              ram_req;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [DATA_WIDTH-1:0] dout;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (s_tdata[ACT_W-1:0]),
		.value   (s_tdata[ACT_W +: DATA_WIDTH]),
		.ram_req (ram_req),
		.res     (res)
	);

	cdq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_WIDTH),
		.ADDR_P  (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rd_data)
	);

	assign dout = res_s1.use_rd ? rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (advance) begin
			m_tdata <= {4'b0, res_s1.is_full, res_s1.is_empty, res_s1.status,
				DIN_W'(dout)};
		end
	end

endmodule

>>> hdl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int DEPTH_P = 64,
	parameter int WIDTH_P = 16,
	parameter int ADDR_P  = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_P-1:0]  waddr,
	input  logic [WIDTH_P-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_P-1:0]  raddr,
	output logic [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Front/rear indices and entry count; decodes a request into a RAM access
// and the status and flags of its result.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [cdq_pkg::ACT_W-1:0]      action,
	input  logic [cdq_pkg::DATA_WIDTH-1:0] value,
	output cdq_pkg::ram_req_t              ram_req,
	output cdq_pkg::res_t                  res
);
	import cdq_pkg::*;

	logic [ADDR_W-1:0] front_q, rear_q, front_d, rear_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              empty, full;

	function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] i);
		return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] i);
		return (i == '0) ? ADDR_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	always_comb begin
		front_d        = front_q;
		rear_d         = rear_q;
		count_d        = count_q;
		ram_req.we     = 1'b0;
		ram_req.waddr  = '0;
		ram_req.wdata  = value;
		ram_req.re     = 1'b0;
		ram_req.raddr  = front_q;
		res.status     = ST_OK;
		res.use_rd     = 1'b0;
		case (action)
			ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
				if (full) begin
					res.status = ST_FULL;
				end else if (empty) begin
					front_d    = '0;
					rear_d     = '0;
					count_d    = CNT_W'(1);
					ram_req.we = accept;
				end else begin
					if (action == ACT_PUSH_FRONT) begin
						front_d       = ring_dec(front_q);
						ram_req.waddr = front_d;
					end else begin
						rear_d        = ring_inc(rear_q);
						ram_req.waddr = rear_d;
					end
					count_d    = count_q + 1'b1;
					ram_req.we = accept;
				end
			end
			ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.use_rd = 1'b1;
					ram_req.re = accept;
					if (action == ACT_POP_REAR || action == ACT_PEEK_REAR) begin
						ram_req.raddr = rear_q;
					end
					if (action == ACT_POP_FRONT || action == ACT_POP_REAR) begin
						count_d = count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							front_d = '0;
							rear_d  = '0;
						end else if (action == ACT_POP_FRONT) begin
							front_d = ring_inc(front_q);
						end else begin
							rear_d = ring_dec(rear_q);
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.is_empty = (count_d == '0);
		res.is_full  = (count_d == CNT_W'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
		end
	end

endmodule

>>> tb/circular_deque_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Drives push, pop and peek requests and unused action codes into the deque
// through its stream interface with random gaps and back-pressure. A scoreboard
// keeps its own ring model, predicts every result word and checks each one in order.
// ----------------------------------------------------------------------------
import cdq_pkg::*;

typedef struct packed {
	logic              is_full;
	logic              is_empty;
	logic [STAT_W-1:0] status;
	logic [15:0]       data_out;
} deque_result_t;

localparam int RES_W = $bits(deque_result_t);

class deque_scoreboard;
	logic [DATA_WIDTH-1:0] ring [DEPTH];
	int                    front_idx;
	int                    rear_idx;
	int                    held;
	deque_result_t         awaited_q [$];
	int                    errors;

	function new();
		front_idx = 0;
		rear_idx  = 0;
		held      = 0;
		errors    = 0;
	endfunction

	function int pending();
		return awaited_q.size();
	endfunction

	function void note_request(logic [ACT_W-1:0] act, logic [DIN_W-1:0] value);
		deque_result_t r;
		r = '0;
		r.status = ST_OK;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else if (held == 0) begin
					front_idx = 0;
					rear_idx  = 0;
					ring[0]   = value[DATA_WIDTH-1:0];
					held      = 1;
				end else if (act == ACT_PUSH_FRONT) begin
					front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
					ring[front_idx] = value[DATA_WIDTH-1:0];
					held++;
				end else begin
					rear_idx = (rear_idx + 1 >= DEPTH) ? 0 : rear_idx + 1;
					ring[rear_idx] = value[DATA_WIDTH-1:0];
					held++;
				end
			end
			ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT)
						r.data_out = 16'(ring[front_idx]);
					else
						r.data_out = 16'(ring[rear_idx]);
					if (act == ACT_POP_FRONT || act == ACT_POP_REAR) begin
						held--;
						if (held == 0) begin
							front_idx = 0;
							rear_idx  = 0;
						end else if (act == ACT_POP_FRONT) begin
							front_idx = (front_idx + 1 >= DEPTH) ? 0 : front_idx + 1;
						end else begin
							rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.is_empty = (held == 0);
		r.is_full  = (held >= DEPTH);
		awaited_q.push_back(r);
	endfunction

	function void report(string field, logic [15:0] want, logic [15:0] got);
		errors++;
		if (errors <= 40)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endfunction

	function void check_result(logic [M_TDATA_W-1:0] word);
		deque_result_t got;
		deque_result_t want;
		got = word[RES_W-1:0];
		if (awaited_q.size() == 0) begin
			errors++;
			if (errors <= 40)
				$display("%0t: unexpected word, expected none, actual %h", $time, word);
			return;
		end
		want = awaited_q.pop_front();
		if (got.data_out !== want.data_out)
			report("data_out", want.data_out, got.data_out);
		if (got.status !== want.status)
			report("status", 16'(want.status), 16'(got.status));
		if (got.is_empty !== want.is_empty)
			report("is_empty", 16'(want.is_empty), 16'(got.is_empty));
		if (got.is_full !== want.is_full)
			report("is_full", 16'(want.is_full), 16'(got.is_full));
	endfunction
endclass

module circular_deque_tb;

	localparam logic [ACT_W-1:0] ACT_SPARE_LO = ACT_PEEK_REAR + 3'd1;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = '1;
	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASE_ITEMS  = 75;
	localparam int DIRECTED_N   = 22;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	deque_scoreboard sb = new();

	int tx_max  = 10;
	int rx_max  = 10;
	int rx_wait = 0;
	int idle_cycles = 0;

	logic [ACT_W-1:0] dir_act [DIRECTED_N] = '{
		ACT_PEEK_FRONT, ACT_PEEK_REAR, ACT_POP_FRONT, ACT_POP_REAR,
		ACT_SPARE_LO, ACT_SPARE_HI,
		ACT_PUSH_FRONT, ACT_PUSH_REAR, ACT_PUSH_FRONT, ACT_PUSH_REAR,
		ACT_PEEK_FRONT, ACT_PEEK_REAR, ACT_SPARE_LO,
		ACT_POP_FRONT, ACT_POP_REAR, ACT_POP_FRONT, ACT_POP_REAR,
		ACT_PUSH_REAR, ACT_PUSH_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_POP_FRONT
	};
	logic [DIN_W-1:0] dir_val [DIRECTED_N] = '{
		16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF,
		16'hFFFF, 16'h0000,
		16'hFFFF, 16'h0000, 16'h5A5A, 16'hA5A5,
		16'hFFFF, 16'h0000, 16'hFFFF,
		16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
		16'h1234, 16'h8001, 16'hFFFF, 16'h0000, 16'hFFFF
	};

	phase_t schedule [6] = '{PH_FILL, PH_FILL, PH_MIX, PH_DRAIN, PH_DRAIN, PH_MIX};

	circular_deque uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// one request word, held until the deque takes it
	task automatic send_request(logic [ACT_W-1:0] act, logic [DIN_W-1:0] value);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - ACT_W - DIN_W){1'b0}}, value, act};
		do @(posedge clk); while (!s_tready);
		sb.note_request(act, value);
	endtask

	function automatic logic [ACT_W-1:0] pick_action(phase_t ph);
		int r;
		int push_pct;
		r = $urandom_range(0, 99);
		push_pct = (ph == PH_FILL) ? 80 : (ph == PH_DRAIN) ? 15 : 45;
		if (r < 2)
			return $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
		if (r < 2 + push_pct)
			return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
		case ($urandom_range(0, 5))
			0, 1: return ACT_POP_FRONT;
			2, 3: return ACT_POP_REAR;
			4: return ACT_PEEK_FRONT;
			default: return ACT_PEEK_REAR;
		endcase
	endfunction

	function automatic logic [DIN_W-1:0] pick_value();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? '1 : '0;
		return DIN_W'($urandom());
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
			rx_wait = $urandom_range(0, rx_max);
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		m_tready <= (rx_wait == 0);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_request(dir_act[i], dir_val[i]);

		for (int p = 0; p < 6; p++) begin
			// drain the output side completely before each phase
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (sb.pending() != 0) @(posedge clk);
			tx_max = (p == 2) ? 0 : 10;
			rx_max = (p == 2) ? 0 : 10;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_request(pick_action(schedule[p]), pick_value());
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
